// File: src/task_ready_priority_queue_assert.svh
// Assertion macros used by the ready-queue datapath, tprq_dp.
// Expects clk and rst_n to be visible in the module that expands them.
`ifndef TASK_READY_PRIORITY_QUEUE_ASSERT_SVH
`define TASK_READY_PRIORITY_QUEUE_ASSERT_SVH

// Check a condition at every clock edge outside reset.
`define TPRQ_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
    else $error(msg);

// Check that a trigger is followed by a condition in the next cycle.
`define TPRQ_ASSERT_NEXT(lbl, pre, post, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (pre) |=> (post)) \
    else $error(msg);

`endif

// File: src/tprq_pkg.sv
// Shared types and codes for the task ready priority queue.
// No dependencies; used by tprq_ctrl, tprq_dp and the top level.
package tprq_pkg;

  localparam int KIND_W = 2;
  localparam int ID_W   = 8;
  localparam int PRI_W  = 3;
  localparam int ST_W   = 2;

  // Operation codes
  localparam logic [KIND_W-1:0] KIND_PUSH = 2'd0;
  localparam logic [KIND_W-1:0] KIND_POP  = 2'd1;
  localparam logic [KIND_W-1:0] KIND_FIND = 2'd2;

  // Result status codes
  localparam logic [ST_W-1:0] ST_OK               = 2'd0;
  localparam logic [ST_W-1:0] ST_EMPTY_OR_MISSING = 2'd1;
  localparam logic [ST_W-1:0] ST_FULL             = 2'd2;

  // Controller to datapath commands
  typedef struct packed {
    logic load;      // capture the incoming transaction
    logic exec;      // perform push/pop, write the result register
    logic rot_step;  // rotate the row by one entry during a find
  } tprq_cmd_t;

  // Datapath to controller status
  typedef struct packed {
    logic in_find;     // incoming transaction is a find
    logic count_zero;  // queue holds no entries
    logic rot_last;    // this rotation step is the final one
  } tprq_sts_t;

endpackage

// File: src/tprq_ctrl.sv
// Sequencing state machine for the task ready priority queue.
// Depends on tprq_pkg for command and status structs.
module tprq_ctrl (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_stall,
  output logic                out_valid,
  input  logic                out_stall,
  input  tprq_pkg::tprq_sts_t sts,
  output tprq_pkg::tprq_cmd_t cmd
);

  typedef enum logic [1:0] {
    S_IDLE,
    S_FIND,
    S_OP
  } state_t;

  state_t state_r;
  logic   out_valid_r;
  logic   out_free;

  assign out_free  = !out_valid_r || !out_stall;
  assign in_stall  = (state_r != S_IDLE);
  assign out_valid = out_valid_r;

  assign cmd.load     = in_valid && (state_r == S_IDLE);
  assign cmd.exec     = (state_r == S_OP) && out_free;
  assign cmd.rot_step = (state_r == S_FIND);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      if (cmd.exec) begin
        out_valid_r <= 1'b1;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
      unique case (state_r)
        S_IDLE: begin
          if (in_valid) begin
            state_r <= (sts.in_find && !sts.count_zero) ? S_FIND : S_OP;
          end
        end
        S_FIND: begin
          if (sts.rot_last) begin
            state_r <= S_OP;
          end
        end
        S_OP: begin
          if (out_free) begin
            state_r <= S_IDLE;
          end
        end
        default: begin
          state_r <= S_IDLE;
        end
      endcase
    end
  end

endmodule

// File: src/tprq_dp.sv
// Sorted entry row, request and result registers of the ready queue.
// Depends on tprq_pkg and task_ready_priority_queue_assert.svh.
`include "task_ready_priority_queue_assert.svh"

module tprq_dp #(
  parameter int QUEUE_DEPTH = 16
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic [tprq_pkg::KIND_W-1:0]   in_kind,
  input  logic [tprq_pkg::ID_W-1:0]     in_task_id,
  input  logic [tprq_pkg::PRI_W-1:0]    in_priority_req,
  input  tprq_pkg::tprq_cmd_t           cmd,
  output tprq_pkg::tprq_sts_t           sts,
  output logic [tprq_pkg::ST_W-1:0]     out_status,
  output logic [tprq_pkg::ID_W-1:0]     out_task_id,
  output logic [tprq_pkg::PRI_W-1:0]    out_priority,
  output logic                          out_now_empty
);

  localparam int CW = $clog2(QUEUE_DEPTH + 1);

  logic [tprq_pkg::KIND_W-1:0] kind_r;
  logic [tprq_pkg::ID_W-1:0]   req_id_r;
  logic [tprq_pkg::PRI_W-1:0]  req_pri_r;
  logic [CW-1:0]               count_r;
  logic [CW-1:0]               count_nxt;
  logic [CW-1:0]               count_m1;
  logic [CW-1:0]               rot_cnt_r;
  logic                        hit_r;
  logic [tprq_pkg::PRI_W-1:0]  hit_pri_r;

  logic [tprq_pkg::ID_W-1:0]   id_r   [QUEUE_DEPTH];
  logic [tprq_pkg::PRI_W-1:0]  pri_r  [QUEUE_DEPTH];
  logic [tprq_pkg::ID_W-1:0]   id_nxt [QUEUE_DEPTH];
  logic [tprq_pkg::PRI_W-1:0]  pri_nxt[QUEUE_DEPTH];
  logic [tprq_pkg::ID_W-1:0]   id_up  [QUEUE_DEPTH];
  logic [tprq_pkg::PRI_W-1:0]  pri_up [QUEUE_DEPTH];
  logic [tprq_pkg::ID_W-1:0]   id_dn  [QUEUE_DEPTH];
  logic [tprq_pkg::PRI_W-1:0]  pri_dn [QUEUE_DEPTH];
  logic [QUEUE_DEPTH-1:0]      le;
  logic [QUEUE_DEPTH-1:0]      le_prev;

  logic                        full;
  logic                        empty;
  logic                        do_push;
  logic                        do_pop;
  logic                        push_full;

  logic [tprq_pkg::ST_W-1:0]   res_st;
  logic [tprq_pkg::ID_W-1:0]   res_id;
  logic [tprq_pkg::PRI_W-1:0]  res_pri;

  assign full     = (count_r == CW'(QUEUE_DEPTH));
  assign empty    = (count_r == '0);
  assign count_m1 = count_r - CW'(1);

  assign do_push   = cmd.exec && (kind_r == tprq_pkg::KIND_PUSH) && !full;
  assign push_full = cmd.exec && (kind_r == tprq_pkg::KIND_PUSH) && full;
  assign do_pop    = cmd.exec && (kind_r == tprq_pkg::KIND_POP) && !empty;

  assign sts.in_find    = (in_kind == tprq_pkg::KIND_FIND);
  assign sts.count_zero = empty;
  assign sts.rot_last   = (rot_cnt_r == count_m1);

  // Neighbor taps and per-cell "stays ahead of the new entry" flags
  for (genvar g = 0; g < QUEUE_DEPTH; g++) begin : g_cell
    assign le[g] = (CW'(g) < count_r) && (pri_r[g] <= req_pri_r);
    if (g == 0) begin : g_head
      assign id_dn[g]   = id_r[g];
      assign pri_dn[g]  = pri_r[g];
      assign le_prev[g] = 1'b1;
    end else begin : g_body
      assign id_dn[g]   = id_r[g-1];
      assign pri_dn[g]  = pri_r[g-1];
      assign le_prev[g] = le[g-1];
    end
    if (g == QUEUE_DEPTH - 1) begin : g_tail
      assign id_up[g]  = id_r[g];
      assign pri_up[g] = pri_r[g];
    end else begin : g_mid
      assign id_up[g]  = id_r[g+1];
      assign pri_up[g] = pri_r[g+1];
    end
  end

  // Each cell picks: hold, take the new entry, shift down, shift up or wrap
  always_comb begin
    for (int i = 0; i < QUEUE_DEPTH; i++) begin
      id_nxt[i]  = id_r[i];
      pri_nxt[i] = pri_r[i];
      if (do_push) begin
        if (!le[i]) begin
          if (le_prev[i]) begin
            id_nxt[i]  = req_id_r;
            pri_nxt[i] = req_pri_r;
          end else begin
            id_nxt[i]  = id_dn[i];
            pri_nxt[i] = pri_dn[i];
          end
        end
      end else if (do_pop) begin
        id_nxt[i]  = id_up[i];
        pri_nxt[i] = pri_up[i];
      end else if (cmd.rot_step) begin
        if (CW'(i) == count_m1) begin
          id_nxt[i]  = id_r[0];
          pri_nxt[i] = pri_r[0];
        end else begin
          id_nxt[i]  = id_up[i];
          pri_nxt[i] = pri_up[i];
        end
      end
    end
  end

  always_comb begin
    count_nxt = count_r;
    if (do_push) begin
      count_nxt = count_r + CW'(1);
    end else if (do_pop) begin
      count_nxt = count_m1;
    end
  end

  always_comb begin
    res_st  = tprq_pkg::ST_OK;
    res_id  = '0;
    res_pri = '0;
    unique case (kind_r)
      tprq_pkg::KIND_PUSH: begin
        if (full) begin
          res_st = tprq_pkg::ST_FULL;
        end
      end
      tprq_pkg::KIND_POP: begin
        if (empty) begin
          res_st = tprq_pkg::ST_EMPTY_OR_MISSING;
        end else begin
          res_id  = id_r[0];
          res_pri = pri_r[0];
        end
      end
      tprq_pkg::KIND_FIND: begin
        if (hit_r) begin
          res_id  = req_id_r;
          res_pri = hit_pri_r;
        end else begin
          res_st = tprq_pkg::ST_EMPTY_OR_MISSING;
        end
      end
      default: begin
        res_st = tprq_pkg::ST_OK;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    for (int i = 0; i < QUEUE_DEPTH; i++) begin
      id_r[i]  <= id_nxt[i];
      pri_r[i] <= pri_nxt[i];
    end
  end

  // Entry count update and find bookkeeping
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r   <= '0;
      rot_cnt_r <= '0;
      hit_r     <= 1'b0;
    end else begin
      count_r <= count_nxt;
      if (cmd.load) begin
        rot_cnt_r <= '0;
        hit_r     <= 1'b0;
      end else if (cmd.rot_step) begin
        rot_cnt_r <= rot_cnt_r + CW'(1);
        if (!hit_r && (id_r[0] == req_id_r)) begin
          hit_r <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      kind_r    <= in_kind;
      req_id_r  <= in_task_id;
      req_pri_r <= in_priority_req;
    end
    if (cmd.rot_step && !hit_r && (id_r[0] == req_id_r)) begin
      hit_pri_r <= pri_r[0];
    end
    if (cmd.exec) begin
      out_status    <= res_st;
      out_task_id   <= res_id;
      out_priority  <= res_pri;
      out_now_empty <= (count_nxt == '0);
    end
  end

  `TPRQ_ASSERT(a_count_bound, count_r <= CW'(QUEUE_DEPTH), "entry count above depth")
  `TPRQ_ASSERT_NEXT(a_full_push_drop, push_full, $stable(count_r), "full push changed count")
  `TPRQ_ASSERT_NEXT(a_rot_keeps_count, cmd.rot_step, $stable(count_r), "find changed count")
  `TPRQ_ASSERT_NEXT(a_pop_count, do_pop, count_r == $past(count_r) - CW'(1), "pop miscounted")

endmodule

// File: src/task_ready_priority_queue.sv
// Task ready priority queue: sorted by priority (smaller first), FIFO among equals.
// Push, pop and no-op requests pass from acceptance through the execute state to the
// result registers; a find first runs the one-entry-per-cycle rotation of the sorted
// row past the head compare, once for each of the N entries. A stalled result delays both.
// A new transaction is taken only after the previous one has written its result.
// Synchronous active-low reset empties the queue and clears the result valid;
// entry storage is not cleared.
module task_ready_priority_queue #(
  parameter int QUEUE_DEPTH = 16
) (
  input  logic                        clk,
  input  logic                        rst_n,
  // input channel
  input  logic                        in_valid,
  output logic                        in_stall,
  input  logic [tprq_pkg::KIND_W-1:0] in_kind,
  input  logic [tprq_pkg::ID_W-1:0]   in_task_id,
  input  logic [tprq_pkg::PRI_W-1:0]  in_priority_req,
  // result channel
  output logic                        out_valid,
  input  logic                        out_stall,
  output logic [tprq_pkg::ST_W-1:0]   out_status,
  output logic [tprq_pkg::ID_W-1:0]   out_task_id,
  output logic [tprq_pkg::PRI_W-1:0]  out_priority,
  output logic                        out_now_empty
);

  // Commands flow controller -> datapath, status flows back.
  tprq_pkg::tprq_cmd_t cmd;
  tprq_pkg::tprq_sts_t sts;

  // The controller accepts a transaction only when idle, runs the find
  // rotation, and holds the execute step until the result register is free,
  // so a new transaction is taken while the previous result still waits.
  tprq_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .sts       (sts),
    .cmd       (cmd)
  );

  // The datapath holds the sorted row of cells; a push inserts the new entry
  // by local compare-and-shift, a pop shifts toward the head, and a find
  // rotates the row once around while comparing ids at the head.
  tprq_dp #(
    .QUEUE_DEPTH (QUEUE_DEPTH)
  ) u_dp (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_kind         (in_kind),
    .in_task_id      (in_task_id),
    .in_priority_req (in_priority_req),
    .cmd             (cmd),
    .sts             (sts),
    .out_status      (out_status),
    .out_task_id     (out_task_id),
    .out_priority    (out_priority),
    .out_now_empty   (out_now_empty)
  );

endmodule
